[src/two_row_grid_connectivity_top_macros.svh]
// Assertion macros used by the checker.
`ifndef TWO_ROW_GRID_CONNECTIVITY_TOP_MACROS_SVH
`define TWO_ROW_GRID_CONNECTIVITY_TOP_MACROS_SVH

// Same-cycle implication.
`define TRGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("trgc check failed");

// Next-cycle implication.
`define TRGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trgc check failed");

`endif

[src/trgc_pkg.sv]
`default_nettype none
package trgc_pkg;
	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int RESET_COLUMNS   = 1024;
	localparam int COL_W           = 11;
	localparam int ACT_W           = 2;

	localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_ASK   = 2'd2;

	typedef struct packed {
		logic ry;
		logic rx;
		logic bt;
		logic tb;
		logic bb;
		logic tt;
		logic rv;
		logic lv;
	} node_t;

	localparam node_t LEAF_INIT = '{ry: 1'b0, rx: 1'b0, bt: 1'b0, tb: 1'b0,
		bb: 1'b1, tt: 1'b1, rv: 1'b0, lv: 1'b0};

	function automatic node_t leaf_node(logic v, logic rx, logic ry);
		node_t n;
		n.lv = v;
		n.rv = v;
		n.tb = v;
		n.bt = v;
		n.tt = 1'b1;
		n.bb = 1'b1;
		n.rx = rx;
		n.ry = ry;
		return n;
	endfunction
endpackage
`default_nettype wire

[src/trgc_ram.sv]
`default_nettype none
module trgc_ram import trgc_pkg::*; #(
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire node_t         wdata,
	input  wire logic [AW-1:0] raddr_a,
	output node_t              rdata_a,
	input  wire logic [AW-1:0] raddr_b,
	output node_t              rdata_b
);
	node_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

[src/trgc_join.sv]
`default_nettype none
module trgc_join import trgc_pkg::*; (
	input  wire logic  a_vld,
	input  wire node_t a,
	input  wire logic  b_vld,
	input  wire node_t b,
	output node_t      y
);
	node_t j;
	logic  x;
	logic  z;

	always_comb begin
		x    = a.rx;
		z    = a.ry;
		j.lv = a.lv | (a.tt & a.bb & x & z & b.lv);
		j.rv = b.rv | (b.tt & b.bb & x & z & a.rv);
		j.tt = (a.tt & x & b.tt) | (a.tb & z & b.bt);
		j.bb = (a.bb & z & b.bb) | (a.bt & x & b.tb);
		j.tb = (x & a.tt & b.tb) | (z & a.tb & b.bb);
		j.bt = (z & a.bb & b.bt) | (x & a.bt & b.tt);
		j.rx = b.rx;
		j.ry = b.ry;
		if (!a_vld) begin
			y = b;
		end else if (!b_vld) begin
			y = a;
		end else begin
			y = j;
		end
	end
endmodule
`default_nettype wire

[src/two_row_grid_connectivity_top.sv]
// Open/close: the leaf-to-root walk, with L = clog2(MAX_COLUMNS), climbs one level per
// UPD_REQ/UPD_JOIN pair through the shared merge unit. Ask: three range merges, each
// climbing by Q_REQ, Q_ACCL and Q_ACCR per tree level over L+1 levels on the dual-read node memory.
// One item at a time.
// Reset and every columns_in_use write run a clearing pass over every word of the node
// memory; no beat is accepted until it ends. A result waits in an output register.
`default_nettype none
module two_row_grid_connectivity_top import trgc_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [31:0]      s_tdata,   // action[1:0] row_a[2] col_a[13:3] row_b[14] col_b[25:15]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,   // connected[0]
	input  wire logic             cfg_we,
	input  wire logic [COL_W-1:0] cfg_wdata
);
	localparam int L  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int AW = L + 1;
	localparam int IW = L + 2;
	localparam logic [IW-1:0] LEAF_BASE = IW'(2**L);
	localparam logic [31:0] MAX_C = 32'(MAX_COLUMNS);
	localparam int RST_C = (RESET_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RESET_COLUMNS;

	typedef enum logic [10:0] {
		ST_CLR      = 11'b000_0000_0001,
		ST_IDLE     = 11'b000_0000_0010,
		ST_UPD_LEAF = 11'b000_0000_0100,
		ST_UPD_SET  = 11'b000_0000_1000,
		ST_UPD_REQ  = 11'b000_0001_0000,
		ST_UPD_JOIN = 11'b000_0010_0000,
		ST_Q_SET    = 11'b000_0100_0000,
		ST_Q_REQ    = 11'b000_1000_0000,
		ST_Q_ACCL   = 11'b001_0000_0000,
		ST_Q_ACCR   = 11'b010_0000_0000,
		ST_Q_FIN    = 11'b100_0000_0000
	} state_t;

	state_t           st_q;
	logic [AW-1:0]    clr_q;
	logic [COL_W-1:0] n_q;
	logic             ra_q, rb_q, open_q, is_col_q;
	logic [COL_W-1:0] ca_q, cb_q;
	logic [AW-1:0]    k_q;
	node_t            cur_q;
	logic [IW-1:0]    lo_q, hi_q;
	logic             accl_v_q, accr_v_q;
	node_t            accl_q, accr_q, s1_q, s2_q;
	logic [1:0]       rng_q;
	logic             ans_q, ans_pend_q;
	logic             m_tvalid_q, conn_q;

	logic [ACT_W-1:0] act;
	logic             ra_i, rb_i, ra2, rb2, ok, is_col, is_row;
	logic [COL_W-1:0] ca_i, cb_i, ca2, cb2, n_sat, l_col, r_col;

	logic          we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	node_t         wdata, rdata_a, rdata_b, leaf_new;
	logic          ja_v, jb_v;
	node_t         ja, jb, jy;
	logic          lw, rw, yes;

	assign act  = s_tdata[1:0];
	assign ra_i = s_tdata[2];
	assign ca_i = s_tdata[13:3];
	assign rb_i = s_tdata[14];
	assign cb_i = s_tdata[25:15];

	always_comb begin
		ok  = (ca_i != '0) && (ca_i <= n_q) && (cb_i != '0) && (cb_i <= n_q);
		ca2 = ca_i;
		cb2 = cb_i;
		ra2 = ra_i;
		rb2 = rb_i;
		if (ok && (cb_i < ca_i)) begin
			ca2 = cb_i;
			cb2 = ca_i;
			ra2 = rb_i;
			rb2 = ra_i;
		end
		is_col = (ra2 != rb2) && (ca2 == cb2);
		is_row = (ra2 == rb2) && (cb2 == ca2 + COL_W'(1));
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			n_sat = COL_W'(1);
		end else if (32'(cfg_wdata) > MAX_C) begin
			n_sat = COL_W'(MAX_COLUMNS);
		end else begin
			n_sat = cfg_wdata;
		end
	end

	always_comb begin
		case (rng_q)
			2'd0: begin
				l_col = COL_W'(1);
				r_col = ca_q;
			end
			2'd1: begin
				l_col = ca_q;
				r_col = cb_q;
			end
			default: begin
				l_col = cb_q;
				r_col = n_q;
			end
		endcase
	end

	always_comb begin
		leaf_new = leaf_node(rdata_a.lv, rdata_a.rx, rdata_a.ry);
		if (is_col_q) begin
			leaf_new = leaf_node(open_q, rdata_a.rx, rdata_a.ry);
		end else if (ra_q) begin
			leaf_new = leaf_node(rdata_a.lv, rdata_a.rx, open_q);
		end else begin
			leaf_new = leaf_node(rdata_a.lv, open_q, rdata_a.ry);
		end
	end

	always_comb begin
		ja_v = 1'b1;
		jb_v = 1'b1;
		ja   = accl_q;
		jb   = accr_q;
		case (st_q)
			ST_UPD_JOIN: begin
				ja = k_q[0] ? rdata_a : cur_q;
				jb = k_q[0] ? cur_q : rdata_a;
			end
			ST_Q_ACCL: begin
				ja_v = accl_v_q;
				ja   = accl_q;
				jb   = rdata_a;
			end
			ST_Q_ACCR: begin
				ja   = rdata_b;
				jb_v = accr_v_q;
				jb   = accr_q;
			end
			default: begin
				ja_v = accl_v_q;
				jb_v = accr_v_q;
			end
		endcase
	end

	trgc_join u_join (
		.a_vld (ja_v),
		.a     (ja),
		.b_vld (jb_v),
		.b     (jb),
		.y     (jy)
	);

	always_comb begin
		lw = s1_q.rv;
		rw = jy.lv;
		if (ra_q && rb_q) begin
			yes = s2_q.bb | (lw & s2_q.tb) | (s2_q.bt & rw) | (lw & s2_q.tt & rw);
		end else if (!ra_q && !rb_q) begin
			yes = s2_q.tt | (lw & s2_q.bt) | (s2_q.tb & rw) | (lw & s2_q.bb & rw);
		end else if (ra_q) begin
			yes = s2_q.bt | (lw & s2_q.tt) | (s2_q.bb & rw) | (lw & s2_q.tb & rw);
		end else begin
			yes = s2_q.tb | (lw & s2_q.bb) | (s2_q.tt & rw) | (lw & s2_q.bt & rw);
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = clr_q[AW-1] ? LEAF_INIT : '0;
		case (st_q)
			ST_CLR: begin
				we = 1'b1;
			end
			ST_UPD_SET: begin
				we    = 1'b1;
				waddr = k_q;
				wdata = leaf_new;
			end
			ST_UPD_JOIN: begin
				we    = 1'b1;
				waddr = k_q >> 1;
				wdata = jy;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (st_q)
			ST_UPD_LEAF: raddr_a = k_q;
			ST_UPD_REQ:  raddr_a = k_q ^ AW'(1);
			default:     raddr_a = lo_q[AW-1:0];
		endcase
		raddr_b = AW'(hi_q - IW'(1));
	end

	trgc_ram #(.AW(AW)) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign s_tready = (st_q == ST_IDLE) && !ans_pend_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, conn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLR;
			clr_q      <= '0;
			n_q        <= COL_W'(RST_C);
			rng_q      <= '0;
			accl_v_q   <= 1'b0;
			accr_v_q   <= 1'b0;
			ans_pend_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ans_pend_q && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				ans_pend_q <= 1'b0;
			end
			if (cfg_we) begin
				n_q   <= n_sat;
				clr_q <= '0;
				st_q  <= ST_CLR;
			end else begin
				case (st_q)
					ST_CLR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == '1) begin
							st_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (s_tvalid && s_tready) begin
							if (act == ACT_ASK) begin
								if (ok) begin
									rng_q <= '0;
									st_q  <= ST_Q_SET;
								end else begin
									ans_pend_q <= 1'b1;
								end
							end else if ((act == ACT_OPEN || act == ACT_CLOSE) && ok &&
								(is_col || is_row)) begin
								st_q <= ST_UPD_LEAF;
							end
						end
					end
					ST_UPD_LEAF: st_q <= ST_UPD_SET;
					ST_UPD_SET:  st_q <= ST_UPD_REQ;
					ST_UPD_REQ:  st_q <= ST_UPD_JOIN;
					ST_UPD_JOIN: begin
						st_q <= ((k_q >> 1) == AW'(1)) ? ST_IDLE : ST_UPD_REQ;
					end
					ST_Q_SET: begin
						accl_v_q <= 1'b0;
						accr_v_q <= 1'b0;
						st_q     <= ST_Q_REQ;
					end
					ST_Q_REQ: st_q <= (lo_q < hi_q) ? ST_Q_ACCL : ST_Q_FIN;
					ST_Q_ACCL: begin
						if (lo_q[0]) begin
							accl_v_q <= 1'b1;
						end
						st_q <= ST_Q_ACCR;
					end
					ST_Q_ACCR: begin
						if (hi_q[0]) begin
							accr_v_q <= 1'b1;
						end
						st_q <= ST_Q_REQ;
					end
					ST_Q_FIN: begin
						rng_q <= rng_q + 2'd1;
						if (rng_q == 2'd2) begin
							ans_pend_q <= 1'b1;
							st_q       <= ST_IDLE;
						end else begin
							st_q <= ST_Q_SET;
						end
					end
					default: st_q <= ST_CLR;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					ra_q     <= ra2;
					rb_q     <= rb2;
					ca_q     <= ca2;
					cb_q     <= cb2;
					open_q   <= (act == ACT_OPEN);
					is_col_q <= is_col;
					ans_q    <= 1'b0;
					k_q      <= AW'(LEAF_BASE + IW'(ca2) - IW'(1));
				end
			end
			ST_UPD_SET: begin
				cur_q <= leaf_new;
			end
			ST_UPD_JOIN: begin
				cur_q <= jy;
				k_q   <= k_q >> 1;
			end
			ST_Q_SET: begin
				lo_q <= LEAF_BASE + IW'(l_col) - IW'(1);
				hi_q <= LEAF_BASE + IW'(r_col);
			end
			ST_Q_ACCL: begin
				if (lo_q[0]) begin
					accl_q <= jy;
				end
				lo_q <= lo_q + IW'(lo_q[0]);
			end
			ST_Q_ACCR: begin
				if (hi_q[0]) begin
					accr_q <= jy;
				end
				lo_q <= lo_q >> 1;
				hi_q <= (hi_q - IW'(hi_q[0])) >> 1;
			end
			ST_Q_FIN: begin
				case (rng_q)
					2'd0:    s1_q  <= jy;
					2'd1:    s2_q  <= jy;
					default: ans_q <= yes;
				endcase
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
		if (ans_pend_q && (!m_tvalid_q || m_tready)) begin
			conn_q <= ans_q;
		end
	end
endmodule
`default_nettype wire

[src/trgc_check.sv]
`default_nettype none
`include "two_row_grid_connectivity_top_macros.svh"
module trgc_check import trgc_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [31:0]      s_tdata,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [7:0]       m_tdata,
	input wire logic             cfg_we,
	input wire logic [COL_W-1:0] cfg_wdata
);
	logic unused_in;
	assign unused_in = ^{s_tvalid, s_tdata, cfg_wdata};

	`TRGC_ASSERT_NEXT(a_cfg_clear, clk, arst_n, cfg_we, !s_tready)
	`TRGC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))
	`TRGC_ASSERT_NOW(a_out_after_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready))
	`TRGC_ASSERT_NOW(a_out_pad, clk, arst_n, m_tvalid, m_tdata[7:1] == 7'd0)
endmodule

bind two_row_grid_connectivity_top trgc_check u_trgc_check (.*);
`default_nettype wire
